[src/csl_pkg.sv]
// ----------------------------------------------------------------------------
// csl_pkg
// Shared types, character codes, keyword tables and helper functions for the
// C subset lexer.
// ----------------------------------------------------------------------------
package csl_pkg;

	localparam int LENGTH_BITS = 16;
	localparam int TOK_LEN_W   = 16;
	localparam int LEN_WIDE    = (LENGTH_BITS > TOK_LEN_W) ? LENGTH_BITS : TOK_LEN_W;
	localparam int NUM_KW      = 11;
	localparam int KW_ID_W     = 4;
	localparam int KW_POS_W    = 3;
	localparam int KW_TEXT_D   = 2 ** KW_POS_W;

	typedef logic [LENGTH_BITS-1:0] len_t;
	typedef logic [NUM_KW-1:0]      kw_mask_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'd0,
		ST_IDENT  = 4'd1,
		ST_INT    = 4'd2,
		ST_LT     = 4'd3,
		ST_PLUS   = 4'd4,
		ST_ASSIGN = 4'd5,
		ST_MINUS  = 4'd6,
		ST_LINE   = 4'd7,
		ST_BLOCK  = 4'd8,
		ST_SLASH  = 4'd9,
		ST_STRING = 4'd10
	} state_t;

	typedef enum logic [4:0] {
		K_ID      = 5'd0,
		K_KW      = 5'd1,
		K_IL      = 5'd2,
		K_SL      = 5'd3,
		K_AS      = 5'd4,
		K_EQ      = 5'd5,
		K_PLUS    = 5'd6,
		K_INC     = 5'd7,
		K_MINUS   = 5'd8,
		K_DEC     = 5'd9,
		K_MUL     = 5'd10,
		K_DIV     = 5'd11,
		K_NOT     = 5'd12,
		K_AND     = 5'd13,
		K_LT      = 5'd14,
		K_LE      = 5'd15,
		K_GT      = 5'd16,
		K_SC      = 5'd17,
		K_OP      = 5'd18,
		K_CP      = 5'd19,
		K_SLC     = 5'd20,
		K_MLC     = 5'd21,
		K_INVALID = 5'd22
	} kind_t;

	typedef struct packed {
		kind_t                kind;
		logic [TOK_LEN_W-1:0] length;
		logic [KW_ID_W-1:0]   kw_id;
		logic                 last;
	} token_t;

	// Up to two tokens closed by one character word.
	typedef struct packed {
		logic [1:0] count;
		token_t     tok0;
		token_t     tok1;
	} scan_res_t;

	typedef struct packed {
		logic   emit;
		kind_t  kind;
		logic   start;
		state_t st;
	} idle_act_t;

	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NOT     = 8'h21;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_DIG_LO  = 8'h30;
	localparam logic [7:0] CH_DIG_HI  = 8'h39;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_LT      = 8'h3C;
	localparam logic [7:0] CH_EQ      = 8'h3D;
	localparam logic [7:0] CH_GT      = 8'h3E;
	localparam logic [7:0] CH_UP_LO   = 8'h41;
	localparam logic [7:0] CH_UP_HI   = 8'h5A;
	localparam logic [7:0] CH_LBRACK  = 8'h5B;
	localparam logic [7:0] CH_RBRACK  = 8'h5D;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_LOW_LO  = 8'h61;
	localparam logic [7:0] CH_LOW_HI  = 8'h7A;
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;

	// Keyword spellings, zero padded; entries past a keyword's length are never compared.
	localparam logic [7:0] KW_TEXT [NUM_KW][KW_TEXT_D] = '{
		'{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // int
		'{8'h6D, 8'h61, 8'h69, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00}, // main
		'{8'h66, 8'h6C, 8'h6F, 8'h61, 8'h74, 8'h00, 8'h00, 8'h00}, // float
		'{8'h64, 8'h6F, 8'h75, 8'h62, 8'h6C, 8'h65, 8'h00, 8'h00}, // double
		'{8'h63, 8'h68, 8'h61, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00}, // char
		'{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // if
		'{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65, 8'h00, 8'h00, 8'h00}, // while
		'{8'h66, 8'h6F, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // for
		'{8'h62, 8'h72, 8'h65, 8'h61, 8'h6B, 8'h00, 8'h00, 8'h00}, // break
		'{8'h73, 8'h77, 8'h69, 8'h74, 8'h63, 8'h68, 8'h00, 8'h00}, // switch
		'{8'h63, 8'h61, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00}  // case
	};

	localparam logic [KW_POS_W-1:0] KW_LEN [NUM_KW] = '{
		3'd3, 3'd4, 3'd5, 3'd6, 3'd4, 3'd2, 3'd5, 3'd3, 3'd5, 3'd6, 3'd4
	};

	function automatic logic numeral_char(input logic [7:0] c);
		return (c >= CH_DIG_LO) && (c <= CH_DIG_HI);
	endfunction

	function automatic logic name_head_char(input logic [7:0] c);
		return ((c >= CH_LOW_LO) && (c <= CH_LOW_HI)) ||
		       ((c >= CH_UP_LO) && (c <= CH_UP_HI)) || (c == CH_UNDER);
	endfunction

	function automatic logic [TOK_LEN_W-1:0] sat_len(input len_t l);
		logic [LEN_WIDE-1:0] w;
		w = LEN_WIDE'(l);
		if (w > LEN_WIDE'({TOK_LEN_W{1'b1}})) begin
			return '1;
		end
		return w[TOK_LEN_W-1:0];
	endfunction

	// Keywords whose character at position pos equals c.
	function automatic kw_mask_t kw_hit(input logic [7:0] c, input len_t pos);
		kw_mask_t              hit;
		logic                  in_range;
		logic [KW_POS_W-1:0]   p;
		in_range = (LEN_WIDE'(pos) < LEN_WIDE'(KW_TEXT_D));
		p        = pos[KW_POS_W-1:0];
		for (int k = 0; k < NUM_KW; k++) begin
			hit[k] = in_range && (p < KW_LEN[k]) && (KW_TEXT[k][p] == c);
		end
		return hit;
	endfunction

	function automatic token_t mk_tok(input kind_t kind, input len_t l);
		token_t t;
		t        = '0;
		t.kind   = kind;
		t.length = sat_len(l);
		return t;
	endfunction

	function automatic token_t ident_tok(input kw_mask_t mask, input len_t l);
		token_t t;
		logic   found;
		t     = mk_tok(K_ID, l);
		found = 1'b0;
		for (int k = 0; k < NUM_KW; k++) begin
			if (!found && mask[k] && (l == len_t'(KW_LEN[k]))) begin
				t.kind  = K_KW;
				t.kw_id = KW_ID_W'(k);
				found   = 1'b1;
			end
		end
		return t;
	endfunction

	// What a character does when scanned from the idle state.
	function automatic idle_act_t idle_act(input logic [7:0] c);
		idle_act_t a;
		a      = '0;
		a.kind = K_INVALID;
		a.st   = ST_IDLE;
		if (name_head_char(c)) begin
			a.start = 1'b1;
			a.st    = ST_IDENT;
		end else if (numeral_char(c)) begin
			a.start = 1'b1;
			a.st    = ST_INT;
		end else begin
			case (c) inside
				CH_EQ:     begin a.start = 1'b1; a.st = ST_ASSIGN; end
				CH_PLUS:   begin a.start = 1'b1; a.st = ST_PLUS;   end
				CH_MINUS:  begin a.start = 1'b1; a.st = ST_MINUS;  end
				CH_LT:     begin a.start = 1'b1; a.st = ST_LT;     end
				CH_SLASH:  begin a.start = 1'b1; a.st = ST_SLASH;  end
				CH_QUOTE:  begin a.start = 1'b1; a.st = ST_STRING; end
				CH_SEMI:   begin a.emit = 1'b1; a.kind = K_SC;  end
				CH_NOT:    begin a.emit = 1'b1; a.kind = K_NOT; end
				CH_AMP:    begin a.emit = 1'b1; a.kind = K_AND; end
				CH_STAR:   begin a.emit = 1'b1; a.kind = K_MUL; end
				CH_GT:     begin a.emit = 1'b1; a.kind = K_GT;  end
				CH_LPAREN, CH_LBRACE, CH_LBRACK: begin
					a.emit = 1'b1;
					a.kind = K_OP;
				end
				CH_RPAREN, CH_RBRACE, CH_RBRACK: begin
					a.emit = 1'b1;
					a.kind = K_CP;
				end
				CH_SPACE, CH_TAB, CH_NL: begin
				end
				default:   a.emit = 1'b1;
			endcase
		end
		return a;
	endfunction

endpackage

[src/csl_scan.sv]
// ----------------------------------------------------------------------------
// csl_scan
// Scanning automaton: holds the lexeme state and, for the character word in
// the input register, works out the closed tokens and the next state.
// ----------------------------------------------------------------------------
module csl_scan (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [7:0]          char_code,
	input  logic                end_of_input,
	output csl_pkg::scan_res_t  res
);

	csl_pkg::state_t   st_q, st_d;
	csl_pkg::len_t     len_q, len_d, len_grow;
	csl_pkg::kw_mask_t mask_q, mask_d, hit, hit0;
	logic              star_q, star_d;

	csl_pkg::token_t    tok_a, tok_b, tok_c;
	logic               va, vb, vc;
	logic               rescan, done;
	csl_pkg::idle_act_t act;
	logic               word_char;

	assign len_grow  = (len_q == '1) ? len_q : len_q + 1'b1;
	assign hit       = csl_pkg::kw_hit(char_code, len_q);
	assign hit0      = csl_pkg::kw_hit(char_code, '0);
	assign act       = csl_pkg::idle_act(char_code);
	assign word_char = csl_pkg::name_head_char(char_code) || csl_pkg::numeral_char(char_code);

	always_comb begin
		st_d   = st_q;
		len_d  = len_q;
		mask_d = mask_q;
		star_d = star_q;
		tok_a  = '0;
		tok_b  = '0;
		tok_c  = '0;
		va     = 1'b0;
		vb     = 1'b0;
		vc     = 1'b0;
		rescan = 1'b0;
		done   = 1'b0;

		unique case (st_q)
			csl_pkg::ST_IDENT: begin
				if (word_char) begin
					mask_d = mask_q & hit;
					len_d  = len_grow;
				end else begin
					tok_a  = csl_pkg::ident_tok(mask_q, len_q);
					va     = 1'b1;
					rescan = 1'b1;
				end
			end
			csl_pkg::ST_INT: begin
				if (csl_pkg::numeral_char(char_code)) begin
					len_d = len_grow;
				end else begin
					tok_a  = csl_pkg::mk_tok(csl_pkg::K_IL, len_q);
					va     = 1'b1;
					rescan = 1'b1;
				end
			end
			csl_pkg::ST_LT: begin
				va = 1'b1;
				if (char_code == csl_pkg::CH_EQ) begin
					tok_a = csl_pkg::mk_tok(csl_pkg::K_LE, csl_pkg::len_t'(2));
					done  = 1'b1;
				end else begin
					tok_a  = csl_pkg::mk_tok(csl_pkg::K_LT, csl_pkg::len_t'(1));
					rescan = 1'b1;
				end
			end
			csl_pkg::ST_PLUS: begin
				va = 1'b1;
				if (char_code == csl_pkg::CH_PLUS) begin
					tok_a = csl_pkg::mk_tok(csl_pkg::K_INC, csl_pkg::len_t'(2));
					done  = 1'b1;
				end else begin
					tok_a  = csl_pkg::mk_tok(csl_pkg::K_PLUS, csl_pkg::len_t'(1));
					rescan = 1'b1;
				end
			end
			csl_pkg::ST_ASSIGN: begin
				va = 1'b1;
				if (char_code == csl_pkg::CH_EQ) begin
					tok_a = csl_pkg::mk_tok(csl_pkg::K_EQ, csl_pkg::len_t'(2));
					done  = 1'b1;
				end else begin
					tok_a  = csl_pkg::mk_tok(csl_pkg::K_AS, csl_pkg::len_t'(1));
					rescan = 1'b1;
				end
			end
			csl_pkg::ST_MINUS: begin
				va = 1'b1;
				if (char_code == csl_pkg::CH_MINUS) begin
					tok_a = csl_pkg::mk_tok(csl_pkg::K_DEC, csl_pkg::len_t'(2));
					done  = 1'b1;
				end else begin
					tok_a  = csl_pkg::mk_tok(csl_pkg::K_MINUS, csl_pkg::len_t'(1));
					rescan = 1'b1;
				end
			end
			csl_pkg::ST_SLASH: begin
				if (char_code == csl_pkg::CH_SLASH) begin
					st_d  = csl_pkg::ST_LINE;
					len_d = len_grow;
				end else if (char_code == csl_pkg::CH_STAR) begin
					st_d   = csl_pkg::ST_BLOCK;
					star_d = 1'b0;
					len_d  = len_grow;
				end else begin
					tok_a  = csl_pkg::mk_tok(csl_pkg::K_DIV, csl_pkg::len_t'(1));
					va     = 1'b1;
					rescan = 1'b1;
				end
			end
			csl_pkg::ST_LINE: begin
				// The newline ends the comment but is not part of it.
				if (char_code == csl_pkg::CH_NL) begin
					tok_a = csl_pkg::mk_tok(csl_pkg::K_SLC, len_q);
					va    = 1'b1;
					done  = 1'b1;
				end else begin
					len_d = len_grow;
				end
			end
			csl_pkg::ST_BLOCK: begin
				len_d = len_grow;
				if (star_q && (char_code == csl_pkg::CH_SLASH)) begin
					tok_a = csl_pkg::mk_tok(csl_pkg::K_MLC, len_grow);
					va    = 1'b1;
					done  = 1'b1;
				end else begin
					star_d = (char_code == csl_pkg::CH_STAR);
				end
			end
			csl_pkg::ST_STRING: begin
				len_d = len_grow;
				if (char_code == csl_pkg::CH_QUOTE) begin
					tok_a = csl_pkg::mk_tok(csl_pkg::K_SL, len_grow);
					va    = 1'b1;
					done  = 1'b1;
				end
			end
			default: begin
				rescan = 1'b1;
			end
		endcase

		if (rescan || done) begin
			st_d   = csl_pkg::ST_IDLE;
			len_d  = '0;
			mask_d = '1;
			star_d = 1'b0;
		end

		// A character that did not belong to the closed token starts afresh.
		if (rescan) begin
			if (act.emit) begin
				tok_b = csl_pkg::mk_tok(act.kind, csl_pkg::len_t'(1));
				vb    = 1'b1;
			end
			if (act.start) begin
				st_d  = act.st;
				len_d = csl_pkg::len_t'(1);
				if (act.st == csl_pkg::ST_IDENT) begin
					mask_d = hit0;
				end
			end
		end

		if (end_of_input) begin
			vc = 1'b1;
			unique case (st_d)
				csl_pkg::ST_IDENT:  tok_c = csl_pkg::ident_tok(mask_d, len_d);
				csl_pkg::ST_INT:    tok_c = csl_pkg::mk_tok(csl_pkg::K_IL, len_d);
				csl_pkg::ST_LT:     tok_c = csl_pkg::mk_tok(csl_pkg::K_LT, csl_pkg::len_t'(1));
				csl_pkg::ST_PLUS:   tok_c = csl_pkg::mk_tok(csl_pkg::K_PLUS, csl_pkg::len_t'(1));
				csl_pkg::ST_ASSIGN: tok_c = csl_pkg::mk_tok(csl_pkg::K_AS, csl_pkg::len_t'(1));
				csl_pkg::ST_MINUS:  tok_c = csl_pkg::mk_tok(csl_pkg::K_MINUS, csl_pkg::len_t'(1));
				csl_pkg::ST_SLASH:  tok_c = csl_pkg::mk_tok(csl_pkg::K_DIV, csl_pkg::len_t'(1));
				csl_pkg::ST_LINE:   tok_c = csl_pkg::mk_tok(csl_pkg::K_SLC, len_d);
				csl_pkg::ST_BLOCK,
				csl_pkg::ST_STRING: tok_c = csl_pkg::mk_tok(csl_pkg::K_INVALID, len_d);
				default:            vc    = 1'b0;
			endcase
			st_d   = csl_pkg::ST_IDLE;
			len_d  = '0;
			mask_d = '1;
			star_d = 1'b0;
		end

		// At most two of the three token sources fire for one character.
		res.count     = 2'({1'b0, va} + {1'b0, vb} + {1'b0, vc});
		res.tok0      = va ? tok_a : (vb ? tok_b : tok_c);
		res.tok1      = (va && vb) ? tok_b : tok_c;
		res.tok0.last = (res.count == 2'd1);
		res.tok1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= csl_pkg::ST_IDLE;
			len_q  <= '0;
			mask_q <= '1;
			star_q <= 1'b0;
		end else if (en) begin
			st_q   <= st_d;
			len_q  <= len_d;
			mask_q <= mask_d;
			star_q <= star_d;
		end
	end

endmodule

[src/csl_obuf.sv]
// ----------------------------------------------------------------------------
// csl_obuf
// Two-entry result register: takes the tokens of one character word at once
// and hands them out one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module csl_obuf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  csl_pkg::scan_res_t res,
	input  logic               out_stall,
	output logic               out_valid,
	output csl_pkg::token_t    head,
	output logic               room
);

	logic [1:0]      cnt_q;
	csl_pkg::token_t head_q, tail_q;
	logic            pop;

	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && !out_stall;
	assign room      = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && !out_stall);
	assign head      = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= res.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			head_q <= res.tok0;
			tail_q <= res.tok1;
		end else if (pop) begin
			head_q <= tail_q;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result buffer count out of range");

	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop)))
		else $error("tokens loaded over an undelivered token");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !out_stall) |=> (cnt_q == 2'd1 && head_q.last))
		else $error("second token did not move to the head");

	a_pair_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(load && res.count == 2'd2) |=> (!head_q.last && tail_q.last))
		else $error("run marker wrong on a token pair");

endmodule

[src/c_subset_lexer_core.sv]
// ----------------------------------------------------------------------------
// c_subset_lexer_core
// Lexical scanner for a C subset: one source character word in, token words
// (kind, length, keyword index, end-of-run mark) out.
// ----------------------------------------------------------------------------
// Path: an accepted character word passes the input register, then the scan
//   logic into the result register, from which its tokens are offered.
// Throughput: one character word per cycle while each yields at most one
//   token and out_stall is low; a word that yields two tokens holds the input
//   until the first has drained, set by the single token per cycle drained from the result register.
// Reset: arst_n clears the scan state to idle and empties both registers.
// ----------------------------------------------------------------------------
module c_subset_lexer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    char_code,
	input  logic                          end_of_input,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [4:0]                    token_kind,
	output logic [csl_pkg::TOK_LEN_W-1:0] token_length,
	output logic [csl_pkg::KW_ID_W-1:0]   keyword_id,
	output logic                          last_of_run
);

	logic               valid_s1;
	logic [7:0]         char_s1;
	logic               eoi_s1;
	logic               room;
	logic               commit;
	csl_pkg::scan_res_t res;
	csl_pkg::token_t    head;

	assign commit   = valid_s1 && room;
	assign in_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_code;
			eoi_s1  <= end_of_input;
		end
	end

	csl_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (commit),
		.char_code    (char_s1),
		.end_of_input (eoi_s1),
		.res          (res)
	);

	csl_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (commit),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.head      (head),
		.room      (room)
	);

	assign token_kind   = head.kind;
	assign token_length = head.length;
	assign keyword_id   = head.kw_id;
	assign last_of_run  = head.last;

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the C subset lexer core. A short table of character
// words covers the extremes, a two-token word and end-of-input flushes. A long
// line comment then drives the length counter into saturation. Random source
// text built from well-formed lexemes, mixed with noise bytes, follows. Every
// accepted character word is run through a scanner model kept in the bench,
// and every token word that comes out is compared field by field with the
// oldest pending expectation.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int LB = csl_pkg::LENGTH_BITS;
	localparam logic [LB-1:0] ONE_LEN = LB'(1);
	localparam logic [LB-1:0] TWO_LEN = LB'(2);

	typedef struct packed {
		csl_pkg::kind_t                kind;
		logic [csl_pkg::TOK_LEN_W-1:0] len;
		logic [csl_pkg::KW_ID_W-1:0]   kw;
		logic                          last;
	} exp_tok_t;

	typedef struct packed {
		logic [7:0]                    c;
		logic                          eoi;
		logic                          typed;
		csl_pkg::kind_t                kind;
		logic [csl_pkg::TOK_LEN_W-1:0] len;
	} row_t;

	logic                          clk;
	logic                          arst_n       = 1'b0;
	logic                          in_valid     = 1'b0;
	logic                          in_stall;
	logic [7:0]                    char_code    = 8'h00;
	logic                          end_of_input = 1'b0;
	logic                          out_valid;
	logic                          out_stall    = 1'b0;
	logic [4:0]                    token_kind;
	logic [csl_pkg::TOK_LEN_W-1:0] token_length;
	logic [csl_pkg::KW_ID_W-1:0]   keyword_id;
	logic                          last_of_run;

	c_subset_lexer_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.char_code    (char_code),
		.end_of_input (end_of_input),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.token_kind   (token_kind),
		.token_length (token_length),
		.keyword_id   (keyword_id),
		.last_of_run  (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("** c_subset_lexer_core: FAILED **");
		$finish;
	end

	// ------------------------------------------------------------------
	// Scanner model
	// ------------------------------------------------------------------
	csl_pkg::state_t          lx_state;
	logic [LB-1:0]            lx_len;
	logic [csl_pkg::NUM_KW-1:0] lx_alive;
	bit                       lx_star;
	exp_tok_t                 step_tok [2];
	int                       step_n;

	exp_tok_t        token_q [$];
	int              errors;
	bit              hold_req;
	bit              no_gaps;
	int              burst_left;
	logic [7:0]      src_q [$];
	row_t            dir_tab [$];

	function automatic bit alpha_char(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic bit digit_char(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit blank_char(input logic [7:0] c);
		return c == " " || c == "\t" || c == "\n";
	endfunction

	function automatic int kw_size(input int k);
		case (k)
			0, 7:        return 3;
			1, 4, 10:    return 4;
			2, 6, 8:     return 5;
			5:           return 2;
			default:     return 6;
		endcase
	endfunction

	function automatic logic [7:0] kw_char(input int k, input int pos);
		logic [47:0] s;
		case (k)
			0:       s = "int";
			1:       s = "main";
			2:       s = "float";
			3:       s = "double";
			4:       s = "char";
			5:       s = "if";
			6:       s = "while";
			7:       s = "for";
			8:       s = "break";
			9:       s = "switch";
			default: s = "case";
		endcase
		return s[8*(kw_size(k)-1-pos) +: 8];
	endfunction

	function void lx_put(input csl_pkg::kind_t k, input logic [LB-1:0] l, input int kw);
		exp_tok_t t;
		if (step_n >= 2) return;
		t.kind = k;
		if (LB > 16 && l > 65535) t.len = '1;
		else t.len = csl_pkg::TOK_LEN_W'(l);
		t.kw   = csl_pkg::KW_ID_W'(kw);
		t.last = 1'b0;
		step_tok[step_n] = t;
		step_n++;
	endfunction

	function void lx_clear();
		lx_state = csl_pkg::ST_IDLE;
		lx_len   = '0;
		lx_alive = '1;
		lx_star  = 1'b0;
	endfunction

	function void lx_begin(input csl_pkg::state_t st);
		lx_clear();
		lx_state = st;
		lx_len   = ONE_LEN;
	endfunction

	function void lx_grow();
		if (lx_len != '1) lx_len = lx_len + 1'b1;
	endfunction

	// Drop keywords whose spelling does not have c at the current position.
	function void lx_match(input logic [7:0] c);
		for (int k = 0; k < csl_pkg::NUM_KW; k++) begin
			if (!(lx_len < kw_size(k) && kw_char(k, int'(lx_len)) == c)) lx_alive[k] = 1'b0;
		end
	endfunction

	function void lx_emit_ident();
		for (int k = 0; k < csl_pkg::NUM_KW; k++) begin
			if (lx_alive[k] && lx_len == kw_size(k)) begin
				lx_put(csl_pkg::K_KW, lx_len, k);
				return;
			end
		end
		lx_put(csl_pkg::K_ID, lx_len, 0);
	endfunction

	function void lx_idle(input logic [7:0] c);
		if (alpha_char(c)) begin
			lx_clear();
			lx_match(c);
			lx_state = csl_pkg::ST_IDENT;
			lx_len   = ONE_LEN;
		end else if (digit_char(c)) lx_begin(csl_pkg::ST_INT);
		else if (c == "=") lx_begin(csl_pkg::ST_ASSIGN);
		else if (c == "+") lx_begin(csl_pkg::ST_PLUS);
		else if (c == "-") lx_begin(csl_pkg::ST_MINUS);
		else if (c == "<") lx_begin(csl_pkg::ST_LT);
		else if (c == "/") lx_begin(csl_pkg::ST_SLASH);
		else if (c == "\"") lx_begin(csl_pkg::ST_STRING);
		else if (c == ";") lx_put(csl_pkg::K_SC, ONE_LEN, 0);
		else if (c == "!") lx_put(csl_pkg::K_NOT, ONE_LEN, 0);
		else if (c == "&") lx_put(csl_pkg::K_AND, ONE_LEN, 0);
		else if (c == "*") lx_put(csl_pkg::K_MUL, ONE_LEN, 0);
		else if (c == ">") lx_put(csl_pkg::K_GT, ONE_LEN, 0);
		else if (c == "(" || c == "{" || c == "[") lx_put(csl_pkg::K_OP, ONE_LEN, 0);
		else if (c == ")" || c == "}" || c == "]") lx_put(csl_pkg::K_CP, ONE_LEN, 0);
		else if (!blank_char(c)) lx_put(csl_pkg::K_INVALID, ONE_LEN, 0);
	endfunction

	function bit lx_pair(input logic [7:0] c, input logic [7:0] second,
	                     input csl_pkg::kind_t k2, input csl_pkg::kind_t k1);
		if (c == second) begin
			lx_put(k2, TWO_LEN, 0);
			lx_clear();
			return 1'b0;
		end
		lx_put(k1, ONE_LEN, 0);
		lx_clear();
		return 1'b1;
	endfunction

	// Returns 1 when the character closed a pending token and must be scanned again from idle.
	function bit lx_scan(input logic [7:0] c);
		case (lx_state)
			csl_pkg::ST_IDENT: begin
				if (alpha_char(c) || digit_char(c)) begin
					lx_match(c);
					lx_grow();
					return 1'b0;
				end
				lx_emit_ident();
				lx_clear();
				return 1'b1;
			end
			csl_pkg::ST_INT: begin
				if (digit_char(c)) begin
					lx_grow();
					return 1'b0;
				end
				lx_put(csl_pkg::K_IL, lx_len, 0);
				lx_clear();
				return 1'b1;
			end
			csl_pkg::ST_LT:     return lx_pair(c, "=", csl_pkg::K_LE, csl_pkg::K_LT);
			csl_pkg::ST_PLUS:   return lx_pair(c, "+", csl_pkg::K_INC, csl_pkg::K_PLUS);
			csl_pkg::ST_ASSIGN: return lx_pair(c, "=", csl_pkg::K_EQ, csl_pkg::K_AS);
			csl_pkg::ST_MINUS:  return lx_pair(c, "-", csl_pkg::K_DEC, csl_pkg::K_MINUS);
			csl_pkg::ST_SLASH: begin
				if (c == "/") begin
					lx_state = csl_pkg::ST_LINE;
					lx_grow();
					return 1'b0;
				end
				if (c == "*") begin
					lx_state = csl_pkg::ST_BLOCK;
					lx_star  = 1'b0;
					lx_grow();
					return 1'b0;
				end
				lx_put(csl_pkg::K_DIV, ONE_LEN, 0);
				lx_clear();
				return 1'b1;
			end
			csl_pkg::ST_LINE: begin
				if (c == "\n") begin
					lx_put(csl_pkg::K_SLC, lx_len, 0);
					lx_clear();
				end else begin
					lx_grow();
				end
				return 1'b0;
			end
			csl_pkg::ST_BLOCK: begin
				lx_grow();
				if (lx_star && c == "/") begin
					lx_put(csl_pkg::K_MLC, lx_len, 0);
					lx_clear();
				end else begin
					lx_star = (c == "*");
				end
				return 1'b0;
			end
			csl_pkg::ST_STRING: begin
				lx_grow();
				if (c == "\"") begin
					lx_put(csl_pkg::K_SL, lx_len, 0);
					lx_clear();
				end
				return 1'b0;
			end
			default: begin
				lx_clear();
				lx_idle(c);
				return 1'b0;
			end
		endcase
	endfunction

	function void lx_flush();
		case (lx_state)
			csl_pkg::ST_IDENT:  lx_emit_ident();
			csl_pkg::ST_INT:    lx_put(csl_pkg::K_IL, lx_len, 0);
			csl_pkg::ST_LT:     lx_put(csl_pkg::K_LT, ONE_LEN, 0);
			csl_pkg::ST_PLUS:   lx_put(csl_pkg::K_PLUS, ONE_LEN, 0);
			csl_pkg::ST_ASSIGN: lx_put(csl_pkg::K_AS, ONE_LEN, 0);
			csl_pkg::ST_MINUS:  lx_put(csl_pkg::K_MINUS, ONE_LEN, 0);
			csl_pkg::ST_SLASH:  lx_put(csl_pkg::K_DIV, ONE_LEN, 0);
			csl_pkg::ST_LINE:   lx_put(csl_pkg::K_SLC, lx_len, 0);
			csl_pkg::ST_BLOCK,
			csl_pkg::ST_STRING: lx_put(csl_pkg::K_INVALID, lx_len, 0);
			default: ;
		endcase
		lx_clear();
	endfunction

	function void lx_step(input logic [7:0] c, input logic eoi);
		step_n = 0;
		if (lx_scan(c)) lx_idle(c);
		if (eoi) lx_flush();
		if (step_n > 0) step_tok[step_n-1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------
	task report_mismatch(input string what, input int got, input int want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		errors++;
	endtask

	initial begin
		exp_tok_t t;
		errors = 0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (token_q.size() == 0) begin
					report_mismatch("token kind with nothing pending", token_kind, -1);
				end else begin
					t = token_q.pop_front();
					if (token_kind !== t.kind) report_mismatch("token_kind", token_kind, t.kind);
					if (token_length !== t.len)
						report_mismatch("token_length", token_length, t.len);
					if (keyword_id !== t.kw) report_mismatch("keyword_id", keyword_id, t.kw);
					if (last_of_run !== t.last)
						report_mismatch("last_of_run", last_of_run, t.last);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: changes its stall pattern now and then, and holds off once
	// for a long stretch so that the core backs up into its input.
	// ------------------------------------------------------------------
	initial begin
		int hold_left;
		int mode;
		int mode_left;
		int phase;
		bit held;
		hold_left = 0;
		mode      = 0;
		mode_left = 0;
		phase     = 0;
		held      = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held      = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(30, 200);
				end
				mode_left--;
				phase++;
				case (mode)
					0:       out_stall <= 1'b0;
					1:       out_stall <= ($urandom_range(0, 2) == 0);
					2:       out_stall <= (phase % 3 == 0);
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------
	task send_word(input logic [7:0] c, input logic eoi, input logic typed,
	               input csl_pkg::kind_t kind, input int len);
		exp_tok_t t;
		if (!no_gaps) begin
			if (burst_left == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				                                         : $urandom_range(1, 20);
			end
			burst_left--;
		end
		in_valid     <= 1'b1;
		char_code    <= c;
		end_of_input <= eoi;
		do @(posedge clk); while (in_stall !== 1'b0);
		lx_step(c, eoi);
		if (typed) begin
			t.kind = kind;
			t.len  = csl_pkg::TOK_LEN_W'(len);
			t.kw   = '0;
			t.last = 1'b1;
			token_q.push_back(t);
		end else begin
			for (int i = 0; i < step_n; i++) token_q.push_back(step_tok[i]);
		end
	endtask

	task add_row(input logic [7:0] c, input logic eoi, input logic typed,
	             input csl_pkg::kind_t kind, input int len);
		row_t r;
		r.c     = c;
		r.eoi   = eoi;
		r.typed = typed;
		r.kind  = kind;
		r.len   = csl_pkg::TOK_LEN_W'(len);
		dir_tab.push_back(r);
	endtask

	task push_text(input logic [63:0] s, input int n);
		for (int i = n - 1; i >= 0; i--) src_q.push_back(s[8*i +: 8]);
	endtask

	function automatic logic [7:0] word_char();
		case ($urandom_range(0, 3))
			0:       return 8'($urandom_range("a", "z"));
			1:       return 8'($urandom_range("A", "Z"));
			2:       return 8'($urandom_range("0", "9"));
			default: return "_";
		endcase
	endfunction

	function automatic logic [7:0] byte_except(input logic [7:0] banned);
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == banned);
		return b;
	endfunction

	// Appends one lexeme of random shape or a few noise bytes, and maybe a separator, to src_q.
	task gen_lexeme();
		int pick;
		int k;
		int n;
		int v;
		logic [63:0] s;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			repeat ($urandom_range(1, 3)) src_q.push_back(8'($urandom_range(0, 255)));
		end else if (pick < 25) begin
			k = $urandom_range(0, csl_pkg::NUM_KW - 1);
			v = $urandom_range(0, 5);
			n = (v == 2) ? kw_size(k) - 1 : kw_size(k);
			for (int p = 0; p < n; p++)
				src_q.push_back((v == 0 && p == 0) ? kw_char(k, p) - 8'h20 : kw_char(k, p));
			if (v == 1) src_q.push_back(word_char());
		end else if (pick < 40) begin
			v = $urandom_range(0, 2);
			src_q.push_back(v == 0 ? "_" : 8'($urandom_range("a", "z")));
			repeat ($urandom_range(0, 7)) src_q.push_back(word_char());
		end else if (pick < 50) begin
			repeat ($urandom_range(1, 6)) src_q.push_back(8'($urandom_range("0", "9")));
		end else if (pick < 58) begin
			src_q.push_back("\"");
			repeat ($urandom_range(0, 8)) src_q.push_back(byte_except("\""));
			src_q.push_back("\"");
		end else if (pick < 80) begin
			n = 1;
			case ($urandom_range(0, 19))
				0:  begin s = "=="; n = 2; end
				1:        s = "=";
				2:  begin s = "++"; n = 2; end
				3:        s = "+";
				4:  begin s = "--"; n = 2; end
				5:        s = "-";
				6:  begin s = "<="; n = 2; end
				7:        s = "<";
				8:        s = "/";
				9:        s = ";";
				10:       s = "!";
				11:       s = "&";
				12:       s = "*";
				13:       s = ">";
				14:       s = "(";
				15:       s = ")";
				16:       s = "{";
				17:       s = "}";
				18:       s = "[";
				default:  s = "]";
			endcase
			push_text(s, n);
		end else if (pick < 88) begin
			push_text("//", 2);
			repeat ($urandom_range(0, 10)) src_q.push_back(byte_except("\n"));
			if ($urandom_range(0, 7) != 0) src_q.push_back("\n");
		end else begin
			push_text("/*", 2);
			repeat ($urandom_range(0, 10)) begin
				case ($urandom_range(0, 3))
					0:       src_q.push_back("*");
					1:       src_q.push_back("/");
					default: src_q.push_back(8'($urandom_range(0, 255)));
				endcase
			end
			push_text("*/", 2);
		end
		case ($urandom_range(0, 5))
			0:       src_q.push_back(" ");
			1:       src_q.push_back("\t");
			2:       src_q.push_back("\n");
			default: ;
		endcase
	endtask

	initial begin
		row_t       r;
		int         sent;
		logic [7:0] c;
		logic       eoi;
		hold_req   = 1'b0;
		no_gaps    = 1'b0;
		burst_left = 0;
		lx_clear();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: single bytes with obvious results, a keyword, rescans, one of
		// which gives two tokens, a block comment whose opening star cannot close it,
		// a string, and end-of-input flushes of an identifier and a string.
		add_row(";",     1'b0, 1'b1, csl_pkg::K_SC, 1);
		add_row(8'h00,   1'b0, 1'b1, csl_pkg::K_INVALID, 1);
		add_row(8'hFF,   1'b0, 1'b1, csl_pkg::K_INVALID, 1);
		add_row("i",     1'b0, 1'b0, csl_pkg::K_ID, 0);
		add_row("f",     1'b0, 1'b0, csl_pkg::K_ID, 0);
		add_row(" ",     1'b0, 1'b0, csl_pkg::K_ID, 0);
		add_row("_",     1'b0, 1'b0, csl_pkg::K_ID, 0);
		add_row("9",     1'b0, 1'b0, csl_pkg::K_ID, 0);
		add_row("=",     1'b0, 1'b0, csl_pkg::K_ID, 0);
		add_row("=",     1'b0, 1'b0, csl_pkg::K_ID, 0);
		add_row("7",     1'b0, 1'b0, csl_pkg::K_ID, 0);
		add_row("<",     1'b0, 1'b0, csl_pkg::K_ID, 0);
		add_row("=",     1'b0, 1'b0, csl_pkg::K_ID, 0);
		add_row("/",     1'b0, 1'b0, csl_pkg::K_ID, 0);
		add_row("*",     1'b0, 1'b0, csl_pkg::K_ID, 0);
		add_row("/",     1'b0, 1'b0, csl_pkg::K_ID, 0);
		add_row("*",     1'b0, 1'b0, csl_pkg::K_ID, 0);
		add_row("/",     1'b0, 1'b0, csl_pkg::K_ID, 0);
		add_row("\"",    1'b0, 1'b0, csl_pkg::K_ID, 0);
		add_row("@",     1'b0, 1'b0, csl_pkg::K_ID, 0);
		add_row("\"",    1'b0, 1'b0, csl_pkg::K_ID, 0);
		add_row("-",     1'b0, 1'b0, csl_pkg::K_ID, 0);
		add_row("q",     1'b1, 1'b0, csl_pkg::K_ID, 0);
		add_row("\"",    1'b0, 1'b0, csl_pkg::K_ID, 0);
		add_row("a",     1'b1, 1'b0, csl_pkg::K_ID, 0);
		foreach (dir_tab[i]) begin
			r = dir_tab[i];
			send_word(r.c, r.eoi, r.typed, r.kind, int'(r.len));
		end

		// A line comment long enough to saturate the length count.
		no_gaps = 1'b1;
		send_word("/", 1'b0, 1'b0, csl_pkg::K_ID, 0);
		send_word("/", 1'b0, 1'b0, csl_pkg::K_ID, 0);
		repeat ((1 << LB) + 4) send_word("x", 1'b0, 1'b0, csl_pkg::K_ID, 0);
		send_word("\n", 1'b0, 1'b0, csl_pkg::K_ID, 0);
		no_gaps = 1'b0;

		sent = 0;
		while (sent < 1400) begin
			gen_lexeme();
			while (src_q.size() != 0) begin
				c   = src_q.pop_front();
				eoi = ($urandom_range(0, 99) < 2) ||
				      (src_q.size() == 0 && $urandom_range(0, 24) == 0);
				send_word(c, eoi, 1'b0, csl_pkg::K_ID, 0);
				if (!blank_char(c)) sent++;
				if (sent == 60) hold_req = 1'b1;
			end
		end
		// Close whatever token is still open.
		send_word(" ", 1'b1, 1'b0, csl_pkg::K_ID, 0);
		in_valid <= 1'b0;

		while (token_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("** c_subset_lexer_core: PASSED **");
		end else begin
			$display("** c_subset_lexer_core: FAILED **");
		end
		$finish;
	end

endmodule

[c_subset_lexer_core.f]
src/csl_pkg.sv
src/csl_scan.sv
src/csl_obuf.sv
src/c_subset_lexer_core.sv
test/tb_top.sv
